@@ rtl/core/rmq_pkg.sv @@
// Package for the rotation matrix to quaternion core.
// Holds branch codes and fixed widths for the core.
package rmq_pkg;

  localparam int unsigned ElemW = 16;
  localparam int unsigned QuatW = 16;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_e;

endpackage

@@ rtl/core/rmq_div.sv @@
// Pipelined restoring divider for one quotient component: one quotient bit per stage.
// Depends on nothing outside itself; stalls with the shared enable.
module rmq_div #(
  parameter int unsigned NumW = 36,
  parameter int unsigned DenW = 20,
  parameter int unsigned QW   = 36
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic [QW-1:0]   quo_o
);

  // Each stage holds the remaining dividend bits, the partial remainder, the divisor and the quotient so far.
  logic [NumW-1:0] num_q [QW+1];
  logic [DenW:0]   rem_q [QW+1];
  logic [DenW-1:0] den_q [QW+1];
  logic [QW-1:0]   quo_q [QW+1];

  always_comb begin
    num_q[0] = num_i;
    rem_q[0] = '0;
    den_q[0] = den_i;
    quo_q[0] = '0;
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DenW+1:0] trial;
    logic            fits;
    assign trial = {rem_q[k], num_q[k][NumW-1]};
    assign fits  = trial >= {2'b00, den_q[k]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k+1] <= {num_q[k][NumW-2:0], 1'b0};
        rem_q[k+1] <= fits ? (DenW+1)'(trial - {2'b00, den_q[k]}) : trial[DenW:0];
        den_q[k+1] <= den_q[k];
        quo_q[k+1] <= {quo_q[k][QW-2:0], fits};
      end
    end
  end

  assign quo_o = quo_q[QW];

endmodule

@@ rtl/core/rmq_sqrt.sv @@
// Pipelined bit-by-bit integer square root, one result bit per stage.
// Depends on nothing outside itself; stalls with the shared enable.
module rmq_sqrt #(
  parameter int unsigned RadW = 36
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RadW-1:0]   rad_i,
  output logic [RadW/2-1:0] root_o
);

  localparam int unsigned RootW = RadW / 2;

  logic [RadW-1:0]  val_q [RootW+1];
  logic [RootW+1:0] rem_q [RootW+1];
  logic [RootW-1:0] root_q [RootW+1];

  always_comb begin
    val_q[0]  = rad_i;
    rem_q[0]  = '0;
    root_q[0] = '0;
  end

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [RootW+1:0] trial;
    logic [RootW+1:0] test;
    logic             fits;
    assign trial = {rem_q[k][RootW-1:0], val_q[k][RadW-1 -: 2]};
    assign test  = {root_q[k], 2'b01};
    assign fits  = trial >= test;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        val_q[k+1]  <= {val_q[k][RadW-3:0], 2'b00};
        rem_q[k+1]  <= fits ? trial - test : trial;
        root_q[k+1] <= {root_q[k][RootW-2:0], fits};
      end
    end
  end

  assign root_o = root_q[RootW];

endmodule

@@ rtl/core/rotation_matrix_to_quaternion_core.sv @@
// Top level of the rotation matrix to quaternion core (four-branch trace method).
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
//
//  Channel  | Direction | Signals               | Contents
//  ---------+-----------+-----------------------+------------------------------
//  s_axis   | in        | tvalid tready tdata   | nine Q2.14 matrix elements
//  m_axis   | out       | tvalid tready tdata   | w x y z, branch, degenerate
//
// One matrix is accepted every cycle while the output is not stalled. The pipeline
// is a branch stage, a square-root pipeline of one result bit per stage, one rounding
// stage, a divider of one quotient bit per stage and the output register. The whole
// pipeline advances only when its output register is empty or being read, so a stall
// freezes every stage and nothing is lost or repeated.
// Reset clears all valid bits.
module rotation_matrix_to_quaternion_core #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // elem_r0c0 [15:0], r0c1, r0c2, r1c0, r1c1, r1c2, r2c0, r2c1, elem_r2c2 [143:128]
  input  logic [143:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // quat_w [15:0], quat_x, quat_y, quat_z [63:48], branch_taken [65:64],
  // degenerate [66], zero fill [71:67]
  output logic [71:0]  m_axis_tdata
);

  // Signed width of the stage-0 terms: it holds 1.0 plus three element magnitudes.
  localparam int unsigned AW    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  // The radicand is shifted by FRAC_BITS+2 and padded to an even width.
  localparam int unsigned RadW  = 2 * ((AW + FRAC_BITS + 2) / 2);
  localparam int unsigned RootW = RadW / 2;
  // Numerator magnitude is at most 2^16; the quotient never exceeds the dividend.
  localparam int unsigned NumW  = 17 + FRAC_BITS;
  localparam int unsigned QW    = NumW;
  localparam int unsigned Lat   = RootW + QW + 2;
  localparam int unsigned QuatWl = rmq_pkg::QuatW;

  logic en;
  logic [Lat-1:0] vld_q;
  logic out_vld_q;

  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;

  // Stage 0: branch decision, radicand and off-diagonal terms.
  logic signed [AW-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;
  assign a00 = AW'(signed'(s_axis_tdata[15:0]));
  assign a01 = AW'(signed'(s_axis_tdata[31:16]));
  assign a02 = AW'(signed'(s_axis_tdata[47:32]));
  assign a10 = AW'(signed'(s_axis_tdata[63:48]));
  assign a11 = AW'(signed'(s_axis_tdata[79:64]));
  assign a12 = AW'(signed'(s_axis_tdata[95:80]));
  assign a20 = AW'(signed'(s_axis_tdata[111:96]));
  assign a21 = AW'(signed'(s_axis_tdata[127:112]));
  assign a22 = AW'(signed'(s_axis_tdata[143:128]));

  logic signed [AW-1:0] one, tr;
  rmq_pkg::branch_e br_d;
  logic signed [AW-1:0] rad_d;
  logic signed [AW-1:0] n_d [3];
  assign one = AW'(1) << FRAC_BITS;
  assign tr  = a00 + a11 + a22;

  // Numerators ordered by output position, skipping the quarter component.
  always_comb begin
    if (tr > 0) begin
      br_d = rmq_pkg::BR_TRACE; rad_d = tr + one;
      n_d[0] = a21 - a12; n_d[1] = a02 - a20; n_d[2] = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      br_d = rmq_pkg::BR_X; rad_d = one + a00 - a11 - a22;
      n_d[0] = a21 - a12; n_d[1] = a01 + a10; n_d[2] = a02 + a20;
    end else if (a11 > a22) begin
      br_d = rmq_pkg::BR_Y; rad_d = one + a11 - a00 - a22;
      n_d[0] = a02 - a20; n_d[1] = a01 + a10; n_d[2] = a12 + a21;
    end else begin
      br_d = rmq_pkg::BR_Z; rad_d = one + a22 - a00 - a11;
      n_d[0] = a10 - a01; n_d[1] = a02 + a20; n_d[2] = a12 + a21;
    end
  end

  logic signed [AW-1:0] rad_q;
  logic signed [AW-1:0] n_q [3];
  rmq_pkg::branch_e     br_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rad_q <= rad_d;
      n_q   <= n_d;
      br_q  <= br_d;
    end
  end

  // Square root on a clamped radicand; degenerate results are masked later.
  logic             dg0;
  logic [RadW-1:0]  rad_sh;
  logic [RootW-1:0] root;
  assign dg0    = rad_q <= 0;
  assign rad_sh = dg0 ? RadW'(1) : RadW'({rad_q[AW-2:0], {(FRAC_BITS + 2){1'b0}}});

  rmq_sqrt #(.RadW(RadW)) u_sqrt (
    .clk_i(clk_i), .en_i(en), .rad_i(rad_sh), .root_o(root)
  );

  // Side data riding along the square root.
  logic signed [AW-1:0] sn_q [RootW+1][3];
  rmq_pkg::branch_e     sbr_q [RootW+1];
  logic                 sdg_q [RootW+1];
  always_comb begin
    sn_q[0] = n_q; sbr_q[0] = br_q; sdg_q[0] = dg0;
  end
  for (genvar k = 0; k < RootW; k++) begin : g_sside
    always_ff @(posedge clk_i) begin
      if (en) begin
        sn_q[k+1] <= sn_q[k]; sbr_q[k+1] <= sbr_q[k]; sdg_q[k+1] <= sdg_q[k];
      end
    end
  end

  // Rounding stage: magnitudes, signs, rounding offset s/2, quarter term.
  logic [NumW-1:0]   mag_q [3];
  logic [2:0]        neg_q;
  logic [RootW-1:0]  s_q;
  logic [QuatWl-1:0] quarter_q;
  rmq_pkg::branch_e  rbr_q;
  logic              rdg_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_q[i] <= sn_q[RootW][i][AW-1];
        mag_q[i] <= (NumW'(sn_q[RootW][i][AW-1] ? -sn_q[RootW][i] : sn_q[RootW][i])
                     << FRAC_BITS) + NumW'(root >> 1);
      end
      s_q       <= root;
      quarter_q <= (((RootW + 1)'(root) + 2) >> 2) > 32767 ? 16'h7fff
                 : QuatWl'(((RootW + 1)'(root) + 2) >> 2);
      rbr_q     <= sbr_q[RootW];
      rdg_q     <= sdg_q[RootW];
    end
  end

  logic [QW-1:0] quo [3];
  for (genvar i = 0; i < 3; i++) begin : g_div
    rmq_div #(.NumW(NumW), .DenW(RootW), .QW(QW)) u_div (
      .clk_i(clk_i), .en_i(en), .num_i(mag_q[i]), .den_i(s_q), .quo_o(quo[i])
    );
  end

  logic [2:0]        dneg_q [QW+1];
  logic [QuatWl-1:0] dqr_q [QW+1];
  rmq_pkg::branch_e  dbr_q [QW+1];
  logic              ddg_q [QW+1];
  always_comb begin
    dneg_q[0] = neg_q; dqr_q[0] = quarter_q; dbr_q[0] = rbr_q; ddg_q[0] = rdg_q;
  end
  for (genvar k = 0; k < QW; k++) begin : g_dside
    always_ff @(posedge clk_i) begin
      if (en) begin
        dneg_q[k+1] <= dneg_q[k]; dqr_q[k+1] <= dqr_q[k];
        dbr_q[k+1]  <= dbr_q[k];  ddg_q[k+1] <= ddg_q[k];
      end
    end
  end

  // Saturate quotients: positive caps at 32767, negative at -32768.
  logic [QuatWl-1:0] qs [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dneg_q[QW][i]) begin
        qs[i] = (quo[i] >= QW'(32768)) ? 16'h8000 : QuatWl'(-quo[i]);
      end else begin
        qs[i] = (quo[i] >= QW'(32767)) ? 16'h7fff : QuatWl'(quo[i]);
      end
    end
  end

  logic [QuatWl-1:0] w, x, y, z;
  always_comb begin
    case (dbr_q[QW])
      rmq_pkg::BR_TRACE: begin w = dqr_q[QW]; x = qs[0]; y = qs[1]; z = qs[2]; end
      rmq_pkg::BR_X:     begin w = qs[0]; x = dqr_q[QW]; y = qs[1]; z = qs[2]; end
      rmq_pkg::BR_Y:     begin w = qs[0]; x = qs[1]; y = dqr_q[QW]; z = qs[2]; end
      default:           begin w = qs[0]; x = qs[1]; y = qs[2]; z = dqr_q[QW]; end
    endcase
    if (ddg_q[QW]) begin
      w = '0; x = '0; y = '0; z = '0;
    end
  end

  logic [71:0] out_q;
  always_ff @(posedge clk_i) begin
    if (en) out_q <= {5'b0, ddg_q[QW], dbr_q[QW], z, y, x, w};
  end
  assign m_axis_tdata = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[Lat-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[Lat-1];
    end
  end

endmodule
